### design/framed_packet_deframer_xor_check_top_defines.svh
// Assertion macros shared by the deframer checker.
`ifndef FRAMED_PACKET_DEFRAMER_XOR_CHECK_TOP_DEFINES_SVH
`define FRAMED_PACKET_DEFRAMER_XOR_CHECK_TOP_DEFINES_SVH

// Clocked assertion, idle while reset is held low.
`define FPDX_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define FPDX_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/fpdx_pkg.sv
// Shared types and constants for the frame deframer.
package fpdx_pkg;

    localparam int BYTE_W = 8;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_ACCEPT = 2'd1,
        KIND_REJECT = 2'd2
    } t_kind;

    // One result as it travels from the front to the back.
    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] cmd;
        logic [BYTE_W-1:0] data;
    } t_event;

    // Queue status seen by the front.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

### design/fpdx_front.sv
// Front end: start mark hunt, header parse, checksum and result classification.
module fpdx_front #(
    parameter int LEN_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [15:0]                 i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [fpdx_pkg::BYTE_W-1:0] i_byte,
    input  fpdx_pkg::t_q_status         i_q_status,
    output logic                        o_push,
    output fpdx_pkg::t_event            o_event
);
    import fpdx_pkg::*;

    localparam int LEN_BYTES = (LEN_WIDTH + 7) / 8;
    localparam int LCW       = (LEN_BYTES > 1) ? $clog2(LEN_BYTES) : 1;

    typedef enum logic [2:0] {
        ST_HUNT   = 3'd0,
        ST_CMD    = 3'd1,
        ST_LEN    = 3'd2,
        ST_DATA   = 3'd3,
        ST_CHK_HI = 3'd4,
        ST_CHK_LO = 3'd5
    } t_state;

    t_state               r_state, n_state;
    logic [15:0]          r_mark;
    logic [BYTE_W-1:0]    r_wbyte, n_wbyte;
    logic                 r_wfull, n_wfull;
    logic [BYTE_W-1:0]    r_cmd, n_cmd;
    logic [LEN_WIDTH-1:0] r_len, n_len;
    logic [LCW-1:0]       r_lcnt, n_lcnt;
    logic [BYTE_W-1:0]    r_xor, n_xor;
    logic [BYTE_W-1:0]    r_chk, n_chk;

    logic                        accept;
    logic [LEN_WIDTH+BYTE_W-1:0] len_wide;
    logic [LEN_WIDTH-1:0]        len_shift;
    logic                        good;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !i_q_status.full;
    assign accept      = i_valid && o_ready;

    assign len_wide  = {r_len, i_byte};
    assign len_shift = len_wide[LEN_WIDTH-1:0];
    assign good      = (r_chk == '0) && (i_byte == r_xor);

    always_comb begin
        n_state = r_state;
        n_wbyte = r_wbyte;
        n_wfull = r_wfull;
        n_cmd   = r_cmd;
        n_len   = r_len;
        n_lcnt  = r_lcnt;
        n_xor   = r_xor;
        n_chk   = r_chk;
        o_push  = 1'b0;
        o_event.kind = KIND_DATA;
        o_event.cmd  = r_cmd;
        o_event.data = i_byte;
        if (accept) begin
            unique case (r_state)
                ST_CMD: begin
                    n_cmd   = i_byte;
                    n_xor   = r_xor ^ i_byte;
                    n_len   = '0;
                    n_lcnt  = '0;
                    n_state = ST_LEN;
                end
                ST_LEN: begin
                    n_xor = r_xor ^ i_byte;
                    n_len = len_shift;
                    if (r_lcnt == LCW'(LEN_BYTES - 1)) begin
                        n_lcnt  = '0;
                        n_state = (len_shift == '0) ? ST_CHK_HI : ST_DATA;
                    end else begin
                        n_lcnt = r_lcnt + 1'b1;
                    end
                end
                ST_DATA: begin
                    // r_len counts the payload bytes still to come
                    n_xor  = r_xor ^ i_byte;
                    n_len  = r_len - 1'b1;
                    o_push = 1'b1;
                    if (r_len == LEN_WIDTH'(1)) begin
                        n_state = ST_CHK_HI;
                    end
                end
                ST_CHK_HI: begin
                    n_chk   = i_byte;
                    n_state = ST_CHK_LO;
                end
                ST_CHK_LO: begin
                    n_state      = ST_HUNT;
                    n_wfull      = 1'b0;
                    n_wbyte      = '0;
                    o_push       = 1'b1;
                    o_event.kind = good ? KIND_ACCEPT : KIND_REJECT;
                end
                default: begin
                    n_state = ST_HUNT;
                    if (r_wfull && ({r_wbyte, i_byte} == r_mark)) begin
                        n_xor   = r_wbyte ^ i_byte;
                        n_wfull = 1'b0;
                        n_wbyte = '0;
                        n_state = ST_CMD;
                    end else begin
                        n_wbyte = i_byte;
                        n_wfull = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HUNT;
            r_mark  <= '0;
            r_wbyte <= '0;
            r_wfull <= 1'b0;
            r_cmd   <= '0;
            r_len   <= '0;
            r_lcnt  <= '0;
            r_xor   <= '0;
            r_chk   <= '0;
        end else begin
            r_state <= n_state;
            r_wbyte <= n_wbyte;
            r_wfull <= n_wfull;
            r_cmd   <= n_cmd;
            r_len   <= n_len;
            r_lcnt  <= n_lcnt;
            r_xor   <= n_xor;
            r_chk   <= n_chk;
            if (i_cfg_valid && o_cfg_ready) begin
                r_mark <= i_cfg_data;
            end
        end
    end

endmodule

### design/fpdx_queue.sv
// Two-entry result queue between the front and the back.
module fpdx_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  fpdx_pkg::t_event    i_event,
    input  logic                i_pop,
    output fpdx_pkg::t_event    o_event,
    output fpdx_pkg::t_q_status o_status
);
    import fpdx_pkg::*;

    t_event     r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_status.full  = (r_count == 2'd2);
    assign o_status.empty = (r_count == 2'd0);
    assign o_event        = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_event;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### design/fpdx_back.sv
// Back end: formats queued results into the output register.
module fpdx_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fpdx_pkg::t_q_status   i_q_status,
    input  fpdx_pkg::t_event      i_event,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [1:0]            o_kind,
    output logic [2*fpdx_pkg::BYTE_W-1:0] o_data
);
    import fpdx_pkg::*;

    logic              r_valid;
    logic [1:0]        r_kind;
    logic [BYTE_W-1:0] r_cmd;
    logic [BYTE_W-1:0] r_byte;
    logic [BYTE_W-1:0] n_byte;

    // load whenever the register is empty or being drained
    assign o_pop  = !i_q_status.empty && (!r_valid || i_ready);
    assign n_byte = (i_event.kind == KIND_DATA) ? i_event.data : '0;

    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_data  = {r_byte, r_cmd};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind <= i_event.kind;
            r_cmd  <= i_event.cmd;
            r_byte <= n_byte;
        end
    end

endmodule

### design/framed_packet_deframer_xor_check_top.sv
// Top level of the length-prefixed frame deframer with XOR checksum.
// Takes one link byte per cycle and sustains that rate indefinitely while the
// result side keeps taking requests: each byte needs only one registered
// update of the hunt window, header counters and running XOR in the front end.
// Accepted payload bytes come out as kind 0 with the frame
// command in tdata[7:0] and the byte in tdata[15:8]; the last checksum byte of
// a frame yields kind 1 (good) or kind 2 (bad) with a zero data byte. Results
// pass through a two-entry queue and an output register, so input stalls only
// once both are full. The start mark is loaded through the config channel and
// takes effect at the next hunt.
module framed_packet_deframer_xor_check_top #(
    parameter int LEN_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,       // start_mark
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // rx_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // frame_cmd [7:0], data_byte [15:8]
    output logic [1:0]  o_m_axis_tuser    // kind
);
    import fpdx_pkg::*;

    logic      push;
    logic      pop;
    t_event    front_event;
    t_event    queue_event;
    t_q_status q_status;

    fpdx_front #(
        .LEN_WIDTH (LEN_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_byte      (i_s_axis_tdata),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_event     (front_event)
    );

    fpdx_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_event  (front_event),
        .i_pop    (pop),
        .o_event  (queue_event),
        .o_status (q_status)
    );

    fpdx_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_event    (queue_event),
        .o_pop      (pop),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_kind     (o_m_axis_tuser),
        .o_data     (o_m_axis_tdata)
    );

endmodule

### design/fpdx_checker.sv
// Port-level checker for the deframer, bound to the top level.
`include "framed_packet_deframer_xor_check_top_defines.svh"

module fpdx_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser
);

    // results other than payload carry a zero data byte
    `FPDX_ASSERT(a_result_zero_data, i_clk, i_rst_n, (o_m_axis_tvalid && (o_m_axis_tuser != 2'd0)) |-> (o_m_axis_tdata[15:8] == 8'd0), "result request with nonzero data byte")

    // no result request right after reset
    `FPDX_ASSERT(a_quiet_after_reset, i_clk, i_rst_n, !$past(i_rst_n) |-> !o_m_axis_tvalid, "output request valid right after reset")

    // a stalled request stays up
    `FPDX_ASSERT(a_valid_holds, i_clk, i_rst_n, (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid, "output request dropped while stalled")

    // a stalled request keeps its payload
    `FPDX_ASSERT(a_payload_holds, i_clk, i_rst_n, (o_m_axis_tvalid && !i_m_axis_tready) |=> ($stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)), "output payload changed while stalled")

endmodule

bind framed_packet_deframer_xor_check_top fpdx_checker u_fpdx_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

### verif/tb_framed_packet_deframer_xor_check_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the length-prefixed frame deframer with XOR checksum.
module tb_framed_packet_deframer_xor_check_top;
    import fpdx_pkg::*;

    localparam int          LEN_W        = 32;
    localparam int          LEN_BYTES    = (LEN_W + 7) / 8;
    localparam logic [63:0] LEN_MASK     = (64'd1 << LEN_W) - 64'd1;
    localparam int          SETTLE_TICKS = 8;
    localparam int          DRAIN_LIMIT  = 5000;
    localparam int          RANDOM_BYTES = 900;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_CMD    = 3'd1,
        PH_LEN    = 3'd2,
        PH_DATA   = 3'd3,
        PH_CHK_HI = 3'd4,
        PH_CHK_LO = 3'd5
    } t_phase;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [15:0] cfg_data  = '0;
    logic        s_valid   = 1'b0;
    logic [7:0]  s_data    = '0;
    logic        m_ready   = 1'b0;
    logic        cfg_ready;
    logic        s_ready;
    logic        m_valid;
    logic [15:0] m_data;
    logic [1:0]  m_user;

    framed_packet_deframer_xor_check_top #(
        .LEN_WIDTH(LEN_W)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(s_ready),
        .i_s_axis_tdata (s_data),
        .o_m_axis_tvalid(m_valid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (m_data),
        .o_m_axis_tuser (m_user)
    );

    // Deframer shadow state
    logic [15:0] mark_q   = '0;
    t_phase      phase_q  = PH_HUNT;
    logic [7:0]  win_byte = '0;
    logic        win_full = 1'b0;
    logic [7:0]  cmd_q    = '0;
    logic [31:0] len_q    = '0;
    logic [31:0] count_q  = '0;
    logic [7:0]  xor_q    = '0;
    logic [7:0]  chk_hi_q = '0;

    t_event pending_results[$];
    int     mismatch_count = 0;
    int     bytes_sent     = 0;
    int     results_seen   = 0;
    int     frames_sent    = 0;
    int     marks_loaded   = 0;
    bit     src_steady     = 1'b0;
    bit     sink_steady    = 1'b0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // Advance the shadow deframer by one link byte and queue any result.
    function automatic void deframe_predict(input logic [7:0] b);
        logic [63:0] wide;
        logic        good;
        t_event      ev;
        case (phase_q)
            PH_CMD: begin
                cmd_q   = b;
                xor_q   = xor_q ^ b;
                len_q   = '0;
                count_q = '0;
                phase_q = PH_LEN;
            end
            PH_LEN: begin
                xor_q   = xor_q ^ b;
                wide    = (({32'd0, len_q} << 8) | {56'd0, b}) & LEN_MASK;
                len_q   = wide[31:0];
                count_q = count_q + 1;
                if (count_q >= LEN_BYTES) begin
                    count_q = '0;
                    phase_q = (len_q == 0) ? PH_CHK_HI : PH_DATA;
                end
            end
            PH_DATA: begin
                xor_q   = xor_q ^ b;
                count_q = count_q + 1;
                if (count_q >= len_q) begin
                    phase_q = PH_CHK_HI;
                end
                ev = '{kind: KIND_DATA, cmd: cmd_q, data: b};
                pending_results.push_back(ev);
            end
            PH_CHK_HI: begin
                chk_hi_q = b;
                phase_q  = PH_CHK_LO;
            end
            PH_CHK_LO: begin
                good     = (chk_hi_q == 8'd0) && (b == xor_q);
                phase_q  = PH_HUNT;
                win_full = 1'b0;
                win_byte = '0;
                ev = '{kind: good ? KIND_ACCEPT : KIND_REJECT, cmd: cmd_q, data: 8'd0};
                pending_results.push_back(ev);
            end
            default: begin
                phase_q = PH_HUNT;
                if (win_full && {win_byte, b} == mark_q) begin
                    xor_q    = win_byte ^ b;
                    win_full = 1'b0;
                    win_byte = '0;
                    phase_q  = PH_CMD;
                end else begin
                    win_byte = b;
                    win_full = 1'b1;
                end
            end
        endcase
    endfunction

    // Hold valid high across back-to-back requests; drop it only for a gap.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = src_steady ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge i_clk); while (!s_ready);
        deframe_predict(b);
        bytes_sent++;
    endtask

    // fill < 0 gives random payload bytes, else a constant byte.
    task automatic send_frame(input logic [7:0] cmd, input int len, input int fill,
                              input bit bad_lo, input bit bad_hi);
        logic [7:0]  sum;
        logic [7:0]  pb;
        logic [31:0] len_word;
        len_word = len;
        sum = mark_q[15:8] ^ mark_q[7:0] ^ cmd;
        send_byte(mark_q[15:8]);
        send_byte(mark_q[7:0]);
        send_byte(cmd);
        for (int i = LEN_BYTES - 1; i >= 0; i--) begin
            pb  = len_word[8*i +: 8];
            sum = sum ^ pb;
            send_byte(pb);
        end
        for (int i = 0; i < len; i++) begin
            pb  = (fill < 0) ? 8'($urandom) : fill[7:0];
            sum = sum ^ pb;
            send_byte(pb);
        end
        send_byte(bad_hi ? 8'($urandom_range(1, 255)) : 8'd0);
        send_byte(bad_lo ? sum ^ 8'($urandom_range(1, 255)) : sum);
        frames_sent++;
    endtask

    // Line noise that never begins a mark, so hunting stays in hunt.
    task automatic send_noise(input int n);
        logic [7:0] b;
        for (int i = 0; i < n; i++) begin
            do b = 8'($urandom); while (b == mark_q[15:8]);
            send_byte(b);
        end
    endtask

    task automatic drain_results();
        int waited;
        s_valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic load_mark(input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        mark_q = value;
        marks_loaded++;
    endtask

    // Reset mark of zero: a zero pair right after reset opens a frame.
    task automatic test_reset_mark();
        send_frame(8'h00, 0, -1, 1'b0, 1'b0);
        send_frame(8'h3C, 2, 8'h00, 1'b0, 1'b0);
        drain_results();
    endtask

    task automatic test_frame_shapes();
        load_mark(16'hA55A);
        send_frame(8'hFF, 0, -1, 1'b0, 1'b0);
        send_frame(8'h00, 1, 8'hFF, 1'b0, 1'b0);
        send_frame(8'h12, 2, 8'h00, 1'b1, 1'b0);
        send_frame(8'h34, 1, -1, 1'b0, 1'b1);
        // Mark bytes inside a rejected frame must not be rescanned.
        send_frame(8'h55, 3, 8'hA5, 1'b1, 1'b0);
        drain_results();
    endtask

    task automatic test_hunt_window();
        // Sliding window: a leading mark byte repeats before the real mark.
        send_byte(8'hA5);
        send_frame(8'h81, 1, 8'h5A, 1'b0, 1'b0);
        send_noise(2);
        drain_results();
        load_mark(16'hFFFF);
        send_frame(8'hFF, 1, 8'hFF, 1'b0, 1'b0);
        drain_results();
    endtask

    task automatic test_random_stream(input logic [15:0] mark, input int budget);
        int stop_at;
        int pick;
        int len;
        load_mark(mark);
        stop_at = bytes_sent + budget;
        while (bytes_sent < stop_at) begin
            if ($urandom_range(0, 9) == 0) src_steady = !src_steady;
            if ($urandom_range(0, 9) == 0) sink_steady = !sink_steady;
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                send_noise($urandom_range(1, 6));
            end else begin
                if (pick < 20) send_byte(mark_q[15:8]);
                pick = $urandom_range(0, 99);
                if (pick < 3) len = $urandom_range(256, 300);
                else if (pick < 18) len = 0;
                else len = $urandom_range(1, 12);
                pick = $urandom_range(0, 99);
                send_frame(8'($urandom), len, -1, pick < 15, pick >= 15 && pick < 21);
            end
        end
        drain_results();
        src_steady  = 1'b0;
        sink_steady = 1'b0;
    endtask

    // Result side: random stall per request, then compare with the oldest prediction.
    initial begin : result_check
        int     stall;
        t_event want;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = sink_steady ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_ready <= 1'b1;
            do @(posedge i_clk); while (!m_valid);
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d cmd %02h data %02h",
                                          m_user, m_data[7:0], m_data[15:8]));
            end else begin
                want = pending_results.pop_front();
                if (m_user !== 2'(want.kind))
                    report_mismatch($sformatf("kind %0d, want %0d", m_user, want.kind));
                if (m_data[7:0] !== want.cmd)
                    report_mismatch($sformatf("cmd %02h, want %02h", m_data[7:0], want.cmd));
                if (m_data[15:8] !== want.data)
                    report_mismatch($sformatf("data %02h, want %02h", m_data[15:8], want.data));
            end
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_mark();
        test_frame_shapes();
        test_hunt_window();
        test_random_stream(16'hFFFF, RANDOM_BYTES / 4);
        test_random_stream(16'h0000, RANDOM_BYTES / 4);
        test_random_stream(16'($urandom), RANDOM_BYTES / 4);
        test_random_stream({2{8'($urandom)}}, RANDOM_BYTES / 4);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        $display("Sent %0d link bytes in %0d frames under %0d start marks,",
                 bytes_sent, frames_sent, marks_loaded);
        $display("checked %0d results, %0d mismatches.", results_seen, mismatch_count);
        if (mismatch_count == 0) begin
            $display("framed_packet_deframer_xor_check_top test passed");
        end else begin
            $display("framed_packet_deframer_xor_check_top test failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("framed_packet_deframer_xor_check_top test failed");
        $finish;
    end

endmodule
